// ===== hdl/crv_pkg.sv =====
`timescale 1ns / 1ps

package crv_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LINE_W    = 24;
    localparam int GAIN_W    = 15;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [LINE_W-1:0]   line_t;
    typedef logic        [GAIN_W-1:0]   gain_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COMB1_FB    = 3'd0,
        REG_COMB2_FB    = 3'd1,
        REG_COMB3_FB    = 3'd2,
        REG_COMB4_FB    = 3'd3,
        REG_ALLPASS1_FB = 3'd4,
        REG_ALLPASS2_FB = 3'd5,
        REG_DRY_GAIN    = 3'd6,
        REG_WET_GAIN    = 3'd7
    } reg_idx_t;

    localparam gain_t GAIN_RESET [NUM_REGS] = '{
        15'd26378, 15'd27099, 15'd25657, 15'd25035,
        15'd22938, 15'd16384, 15'd22938, 15'd9830
    };

    typedef struct packed {
        logic en;
        logic rd;
        logic wr;
    } line_ctl_t;

    function automatic line_t sat24(logic signed [LINE_W:0] v);
        line_t r;
        if (v[LINE_W] != v[LINE_W-1]) begin
            r = v[LINE_W] ? {1'b1, {(LINE_W-1){1'b0}}} : {1'b0, {(LINE_W-1){1'b1}}};
        end else begin
            r = v[LINE_W-1:0];
        end
        return r;
    endfunction

    function automatic line_t gain_mul(line_t d, gain_t g);
        logic signed [LINE_W+GAIN_W:0] p;
        p = d * $signed({1'b0, g});
        return p[LINE_W+GAIN_W-1:GAIN_W];
    endfunction

endpackage

// ===== hdl/crv_line.sv =====
`timescale 1ns / 1ps

module crv_line #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  crv_pkg::line_ctl_t  ctl,
    input  crv_pkg::line_t      wr_data,
    output crv_pkg::line_t      rd_data
);
    import crv_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    line_t          mem [DEPTH];
    logic [AW-1:0]  pos_reg;
    logic [AW-1:0]  pos_next;
    logic [AW-1:0]  wa_reg;
    logic           fill_reg;
    line_t          q_reg;
    line_t          fwd_reg;
    logic           fwd_sel_reg;
    logic           zero_sel_reg;
    logic           rd_fire;
    logic           wr_fire;

    assign rd_fire  = ctl.en && ctl.rd;
    assign wr_fire  = ctl.en && ctl.wr;
    assign pos_next = (pos_reg == AW'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= 1'b0;
        end else if (rd_fire) begin
            pos_reg <= pos_next;
            if (pos_reg == AW'(DEPTH - 1)) begin
                fill_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_fire) begin
            q_reg        <= mem[pos_reg];
            wa_reg       <= pos_reg;
            fwd_reg      <= wr_data;
            fwd_sel_reg  <= wr_fire && (wa_reg == pos_reg);
            zero_sel_reg <= !fill_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wa_reg] <= wr_data;
        end
    end

    assign rd_data = fwd_sel_reg  ? fwd_reg :
                     zero_sel_reg ? '0      : q_reg;

endmodule

// ===== hdl/crv_mix.sv =====
`timescale 1ns / 1ps

module crv_mix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  crv_pkg::sample_t  dry_sample,
    input  crv_pkg::line_t    wet_sample,
    input  crv_pkg::gain_t    dry_gain,
    input  crv_pkg::gain_t    wet_gain,
    output logic              out_valid,
    output crv_pkg::sample_t  out_sample
);
    import crv_pkg::*;

    localparam int DRY_P_W = SAMPLE_W + GAIN_W + 1;
    localparam int WET_P_W = LINE_W + GAIN_W + 1;
    localparam int MIX_W   = WET_P_W + 1;
    localparam int MAG_W   = 31;
    localparam int SCL_W   = MAG_W + GAIN_W;
    localparam logic signed [MIX_W-1:0] ONE_Q30 = MIX_W'(64'sd1073741824);
    localparam logic [GAIN_W-1:0]       OUT_SCALE = 15'd32767;

    logic signed [DRY_P_W-1:0] p_dry_reg;
    logic signed [WET_P_W-1:0] p_wet_reg;
    logic                      v_prod_reg;
    logic signed [MIX_W-1:0]   mix;
    logic signed [MIX_W-1:0]   mix_clamped;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic                      v_mag_reg;
    logic [SCL_W-1:0]          scaled;
    sample_t                   scaled_s;
    sample_t                   out_sample_reg;
    logic                      out_valid_reg;

    assign mix = MIX_W'(p_dry_reg) + MIX_W'(p_wet_reg);

    always_comb begin
        mix_clamped = mix;
        if (mix > ONE_Q30) begin
            mix_clamped = ONE_Q30;
        end else if (mix < -ONE_Q30) begin
            mix_clamped = -ONE_Q30;
        end
    end

    assign scaled   = SCL_W'(mag_reg) * SCL_W'(OUT_SCALE);
    assign scaled_s = scaled[SCL_W-1:SCL_W-SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_prod_reg    <= 1'b0;
            v_mag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v_prod_reg    <= in_valid;
            v_mag_reg     <= v_prod_reg;
            out_valid_reg <= v_mag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_dry_reg      <= dry_sample * $signed({1'b0, dry_gain});
            p_wet_reg      <= wet_sample * $signed({1'b0, wet_gain});
            neg_reg        <= mix_clamped[MIX_W-1];
            mag_reg        <= mix_clamped[MIX_W-1] ? MAG_W'(-mix_clamped)
                                                   : MAG_W'(mix_clamped);
            out_sample_reg <= neg_reg ? -scaled_s : scaled_s;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

// ===== hdl/comb_allpass_reverb_core.sv =====
`timescale 1ns / 1ps
// Schroeder reverberator: four parallel comb lines, two allpass stages in series,
// dry/wet mix. One signed 16-bit Q1.15 sample per request on s_axis, one
// reverberated sample per request on m_axis, in the same order.
// Gains are written through cfg_wr_en / cfg_addr / cfg_wdata; the user must write
// them only while idle, which the block does not enforce; addresses follow the
// register list (comb1..comb4 feedback, allpass1/2 feedback, dry gain, wet gain).
// Throughput: one sample per cycle while not stalled. Each delay line is a
// single-port-write, registered-read memory; every entry is read and then written
// back through wa_reg, with a bypass for a line short enough that the next sample
// reads that entry. Stages: v1_reg..v4_reg, then mixer product, magnitude, output.
// Reset: gains return to their defaults and every line restarts at position 0;
// entries not yet written since reset read as zero, so no clearing pass is run
// and s_tready is high right after reset.
// Backpressure: the pipeline holds in place while m_tvalid is high and m_tready
// is low; s_tready is low for those cycles.
module comb_allpass_reverb_core #(
    parameter int unsigned COMB1_DELAY    = 1116,
    parameter int unsigned COMB2_DELAY    = 1188,
    parameter int unsigned COMB3_DELAY    = 1277,
    parameter int unsigned COMB4_DELAY    = 1356,
    parameter int unsigned ALLPASS1_DELAY = 225,
    parameter int unsigned ALLPASS2_DELAY = 556
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] in_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] out_sample
    input  logic                               cfg_wr_en,
    input  logic [crv_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [crv_pkg::GAIN_W-1:0]         cfg_wdata
);
    import crv_pkg::*;

    localparam int unsigned COMB_DEPTH [4] = '{COMB1_DELAY, COMB2_DELAY,
                                               COMB3_DELAY, COMB4_DELAY};

    gain_t     gain_reg [NUM_REGS];
    logic      en;

    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    sample_t   x1_reg, x2_reg, x3_reg, x4_reg;
    line_t     u1_reg, y1_reg, y2_reg;

    line_t     comb_d  [4];
    line_t     comb_wr [4];
    logic signed [LINE_W+1:0] comb_total;
    line_t     u1;

    line_t     ap1_d, ap1_wr, y1;
    line_t     ap2_d, ap2_wr, y2;

    line_ctl_t comb_ctl, ap1_ctl, ap2_ctl;
    logic      mix_valid;
    sample_t   mix_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign en       = !mix_valid || m_tready;
    assign s_tready = en;

    assign comb_ctl = '{en: en, rd: s_tvalid, wr: v1_reg};
    assign ap1_ctl  = '{en: en, rd: v1_reg,   wr: v2_reg};
    assign ap2_ctl  = '{en: en, rd: v2_reg,   wr: v3_reg};

    for (genvar g = 0; g < 4; g++) begin : g_comb
        assign comb_wr[g] = sat24((LINE_W+1)'(x1_reg) +
            (LINE_W+1)'(gain_mul(comb_d[g],
                                 gain_reg[REG_IDX_W'(int'(REG_COMB1_FB) + g)])));

        crv_line #(.DEPTH(COMB_DEPTH[g])) u_line (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (comb_ctl),
            .wr_data (comb_wr[g]),
            .rd_data (comb_d[g])
        );
    end

    assign comb_total = (LINE_W+2)'(comb_d[0]) + (LINE_W+2)'(comb_d[1]) +
                        (LINE_W+2)'(comb_d[2]) + (LINE_W+2)'(comb_d[3]);
    assign u1         = comb_total[LINE_W+1:2];

    assign ap1_wr = sat24((LINE_W+1)'(u1_reg) +
                          (LINE_W+1)'(gain_mul(ap1_d, gain_reg[REG_ALLPASS1_FB])));
    assign y1     = sat24((LINE_W+1)'(ap1_d) - (LINE_W+1)'(u1_reg));

    crv_line #(.DEPTH(ALLPASS1_DELAY)) u_ap1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ap1_ctl),
        .wr_data (ap1_wr),
        .rd_data (ap1_d)
    );

    assign ap2_wr = sat24((LINE_W+1)'(y1_reg) +
                          (LINE_W+1)'(gain_mul(ap2_d, gain_reg[REG_ALLPASS2_FB])));
    assign y2     = sat24((LINE_W+1)'(ap2_d) - (LINE_W+1)'(y1_reg));

    crv_line #(.DEPTH(ALLPASS2_DELAY)) u_ap2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ap2_ctl),
        .wr_data (ap2_wr),
        .rd_data (ap2_d)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= s_tdata;
            x2_reg <= x1_reg;
            x3_reg <= x2_reg;
            x4_reg <= x3_reg;
            u1_reg <= u1;
            y1_reg <= y1;
            y2_reg <= y2;
        end
    end

    crv_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (v4_reg),
        .dry_sample (x4_reg),
        .wet_sample (y2_reg),
        .dry_gain   (gain_reg[REG_DRY_GAIN]),
        .wet_gain   (gain_reg[REG_WET_GAIN]),
        .out_valid  (mix_valid),
        .out_sample (mix_sample)
    );

    assign m_tvalid = mix_valid;
    assign m_tdata  = mix_sample;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("pipeline moved during a stall");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 16'h8000))
        else $error("output sample outside the scaled range");
`endif

endmodule

// ===== sim/reverb_checker.sv =====
`timescale 1ns / 1ps

module reverb_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] in_sample
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,   // [15:0] out_sample
    input  logic                          cfg_wr_en,
    input  logic [crv_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [crv_pkg::GAIN_W-1:0]    cfg_wdata,
    output int                            errors,
    output int                            pending
);
    import crv_pkg::*;

    localparam int NUM_LINES = 6;
    localparam int MAX_DEPTH = 2048;
    localparam int LINE_DEPTH [NUM_LINES] = '{1116, 1188, 1277, 1356, 225, 556};
    localparam longint LINE_MAX = 64'sd8388607;
    localparam longint LINE_MIN = -64'sd8388608;
    localparam longint UNITY_Q30 = 64'sd1073741824;

    line_t       taps [NUM_LINES][MAX_DEPTH];
    int unsigned tap_pos [NUM_LINES];
    gain_t       gains [NUM_REGS];
    sample_t     out_due [$];
    sample_t     want;
    sample_t     got;
    int          miss_count = 0;

    function automatic line_t clip24(longint v);
        if (v > LINE_MAX) return line_t'(LINE_MAX);
        if (v < LINE_MIN) return line_t'(LINE_MIN);
        return line_t'(v);
    endfunction

    function automatic longint scale_fb(line_t d, gain_t g);
        return (longint'(d) * longint'(g)) >>> 15;
    endfunction

    // comb lines return the oldest entry; allpass lines return oldest minus input
    function automatic line_t run_line(int k, longint u, bit allpass);
        line_t d;
        line_t y;
        d = taps[k][tap_pos[k]];
        y = allpass ? clip24(longint'(d) - u) : d;
        taps[k][tap_pos[k]] = clip24(u + scale_fb(d, gains[k]));
        tap_pos[k] = (tap_pos[k] + 1 == LINE_DEPTH[k]) ? 0 : tap_pos[k] + 1;
        return y;
    endfunction

    function automatic sample_t reverb_sample(sample_t x);
        longint acc;
        longint mix;
        longint mag;
        longint scaled;
        line_t  wet;
        acc = 0;
        for (int k = 0; k < 4; k++) begin
            acc += run_line(k, x, 1'b0);
        end
        wet = clip24(acc >>> 2);
        wet = run_line(4, wet, 1'b1);
        wet = run_line(5, wet, 1'b1);
        mix = longint'(gains[REG_DRY_GAIN]) * longint'(x)
            + longint'(gains[REG_WET_GAIN]) * longint'(wet);
        if (mix > UNITY_Q30) mix = UNITY_Q30;
        if (mix < -UNITY_Q30) mix = -UNITY_Q30;
        mag = (mix < 0) ? -mix : mix;
        scaled = (mag * 32767) >>> 30;
        return sample_t'((mix < 0) ? -scaled : scaled);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (gains[i]) gains[i] = GAIN_RESET[i];
            foreach (taps[k, j]) taps[k][j] = '0;
            foreach (tap_pos[k]) tap_pos[k] = 0;
            out_due.delete();
        end else begin
            if (cfg_wr_en) begin
                gains[cfg_addr] = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                out_due.push_back(reverb_sample(sample_t'(s_tdata)));
            end
            if (m_tvalid && m_tready) begin
                got = sample_t'(m_tdata);
                if (out_due.size() == 0) begin
                    $error("out_sample: expected none, got %0d", got);
                    miss_count++;
                end else begin
                    want = out_due.pop_front();
                    if (got !== want) begin
                        $error("out_sample: expected %0d, got %0d", want, got);
                        miss_count++;
                    end
                end
            end
        end
        pending <= out_due.size();
        errors  <= miss_count;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import crv_pkg::*;

    typedef enum int {
        MIX_FULL,
        MIX_HOT_POS,
        MIX_HOT_NEG
    } stim_mode_t;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [15:0] in_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [15:0] out_sample
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr = '0;
    logic [GAIN_W-1:0]    cfg_wdata = '0;

    int      errors;
    int      pending;
    int      stall_cycles = 0;
    int      gap_pct = 20;
    int      rx_left = 0;
    bit      tx_quiet = 1'b0;
    bit      rx_quiet = 1'b0;
    gain_t   gains_next [NUM_REGS];
    sample_t directed [10] = '{
        16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
        16'sh5555, 16'shAAAA, 16'sd16384, -16'sd16384, 16'sd12345
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    comb_allpass_reverb_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    reverb_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        if (rx_quiet) begin
            m_tready <= 1'b1;
            rx_left  <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
            rx_left  <= $urandom_range(1, 40);
        end else begin
            m_tready <= 1'b0;
            rx_left  <= $urandom_range(1, 17);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL comb_allpass_reverb_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic sample_t pick_sample(stim_mode_t mode);
        int r;
        r = $urandom_range(0, 15);
        case (mode)
            MIX_HOT_POS: return sample_t'($urandom_range(30000, 32767));
            MIX_HOT_NEG: return sample_t'(-int'($urandom_range(30000, 32768)));
            default: begin
                if (r == 0) return 16'sd32767;
                if (r == 1) return -16'sd32768;
                if (r == 2) return 16'sd0;
                return sample_t'($urandom);
            end
        endcase
    endfunction

    task automatic send(input sample_t v);
        int gap;
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every request has come back out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_gains();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= reg_idx_t'(i);
            cfg_wdata <= gains_next[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input stim_mode_t mode);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    default: gap_pct = 25;
                endcase
            end
            send(pick_sample(mode));
        end
        drain();
    endtask

    task automatic set_feedbacks(input gain_t fb);
        gains_next[REG_COMB1_FB]    = fb;
        gains_next[REG_COMB2_FB]    = fb;
        gains_next[REG_COMB3_FB]    = fb;
        gains_next[REG_COMB4_FB]    = fb;
        gains_next[REG_ALLPASS1_FB] = fb;
        gains_next[REG_ALLPASS2_FB] = fb;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send(directed[i]);
        drain();

        gains_next = GAIN_RESET;
        gains_next[REG_DRY_GAIN] = '1;
        gains_next[REG_WET_GAIN] = '0;
        load_gains();
        send(16'sd32767);
        send(-16'sd32768);
        send(-16'sd1);
        send(16'sd1);
        drain();

        foreach (gains_next[i]) gains_next[i] = gain_t'($urandom_range(0, 32767));
        load_gains();
        run_phase(200, MIX_FULL);

        gains_next = GAIN_RESET;
        load_gains();
        run_phase(300, MIX_FULL);

        set_feedbacks('0);
        gains_next[REG_DRY_GAIN] = '0;
        gains_next[REG_WET_GAIN] = '1;
        load_gains();
        run_phase(300, MIX_FULL);

        // push the feedback to full scale and the mix into its clamp
        set_feedbacks('1);
        gains_next[REG_DRY_GAIN] = '1;
        gains_next[REG_WET_GAIN] = '1;
        load_gains();
        run_phase(350, MIX_HOT_POS);

        set_feedbacks('0);
        gains_next[REG_DRY_GAIN] = gain_t'($urandom_range(0, 32767));
        gains_next[REG_WET_GAIN] = gain_t'($urandom_range(0, 32767));
        load_gains();
        run_phase(150, MIX_FULL);

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        set_feedbacks('1);
        gains_next[REG_DRY_GAIN] = '1;
        gains_next[REG_WET_GAIN] = '1;
        load_gains();
        run_phase(250, MIX_HOT_NEG);

        if (errors == 0 && pending == 0) begin
            $display("PASS comb_allpass_reverb_core");
        end else begin
            $display("FAIL comb_allpass_reverb_core");
        end
        $finish;
    end

endmodule
